// File: hdl/order_statistics_engine_top_macros.svh
// assertion macros for the order statistics engine checker
// no dependencies
`ifndef ORDER_STATISTICS_ENGINE_TOP_MACROS_SVH
`define ORDER_STATISTICS_ENGINE_TOP_MACROS_SVH

// clocked check, off while reset is high
`define OSE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers reset cycles
`define OSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ose_pkg.sv
// shared types, constants and helpers for the order statistics engine
// no dependencies
`default_nettype none

package ose_pkg;

  localparam int MAX_SAMPLES   = 256;
  localparam int SAMPLE_BITS   = 32;
  localparam int VALUE_BITS    = SAMPLE_BITS + 1;
  localparam int CNT_BITS      = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_BITS      = $clog2(MAX_SAMPLES);
  localparam int PCT_BITS      = 7;
  localparam int PCT_CNT_BITS  = 3;
  localparam int NUM_SLOTS     = 4;
  localparam int SLOT_BITS     = 2;
  localparam int KIND_BITS     = 2;
  localparam int TGT_BITS      = PCT_BITS + CNT_BITS;
  localparam int PCT_SCALE     = 100;
  localparam int RES_BITS      = 3;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_PCT_COUNT = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PCT_A     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PCT_B     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_PCT_C     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_PCT_D     = 3'd4;

  localparam logic [PCT_CNT_BITS-1:0] PCT_COUNT_RESET = 3'd4;
  localparam logic [PCT_BITS-1:0]     PCT_A_RESET     = 7'd25;
  localparam logic [PCT_BITS-1:0]     PCT_B_RESET     = 7'd50;
  localparam logic [PCT_BITS-1:0]     PCT_C_RESET     = 7'd90;
  localparam logic [PCT_BITS-1:0]     PCT_D_RESET     = 7'd99;

  localparam logic [RES_BITS-1:0] RES_MIN    = 3'd0;
  localparam logic [RES_BITS-1:0] RES_MAX    = 3'd1;
  localparam logic [RES_BITS-1:0] RES_MEDIAN = 3'd2;
  localparam logic [RES_BITS-1:0] RES_PCT0   = 3'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [VALUE_BITS-1:0]  value_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_MIN,
    KIND_MAX,
    KIND_MEDIAN2,
    KIND_PCT
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic drain;
    logic clear;
  } chain_ctl_t;

  function automatic value_t sext(input sample_t s);
    return {s[SAMPLE_BITS-1], s};
  endfunction

endpackage

`default_nettype wire

// File: hdl/order_statistics_engine_top.sv
// order statistics engine top level: control, statistic capture, register port
// depends on ose_pkg, ose_chain
`default_nettype none

// Samples enter a chain of 256 sorting cells, one item per cycle, with no
// stall while a set is being gathered. The item carrying end_of_set closes
// the set; the input then stalls while the engine forms the percentile
// targets, shifts the N sorted samples out of the head of the chain (the
// only read point of the sorted store) and emits R = 3 to 7 result items,
// in the order minimum, maximum, doubled median, percentile slots, and for
// as long as out_stall holds a waiting result. Samples past 256 in one set
// are dropped and flagged in overflowed. The store needs no clearing pass
// after reset.
module order_statistics_engine_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  ose_pkg::sample_t                       sample,
  input  logic                                   end_of_set,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ose_pkg::KIND_BITS-1:0]          kind,
  output logic [ose_pkg::SLOT_BITS-1:0]          slot,
  output ose_pkg::value_t                        value,
  output logic                                   overflowed,
  output logic                                   final_res,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ose_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [ose_pkg::DATA_BITS-1:0]          pwdata,
  output logic [ose_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready
);
  import ose_pkg::*;

  state_t state, state_next;
  chain_ctl_t ctl;
  sample_t head;

  logic [PCT_CNT_BITS-1:0] pct_count;
  logic [PCT_BITS-1:0]     pct [NUM_SLOTS];

  logic [CNT_BITS-1:0] count;
  logic                overflow;
  logic [CNT_BITS-1:0] n;
  logic [IDX_BITS-1:0] n_m1;
  logic [IDX_BITS-1:0] half;
  logic                odd;
  logic [TGT_BITS-1:0] tgt [NUM_SLOTS];
  logic [TGT_BITS-1:0] acc;
  logic [IDX_BITS-1:0] j;
  logic [RES_BITS-1:0] res_idx;
  logic [RES_BITS-1:0] slots_n;
  logic                got [NUM_SLOTS];

  sample_t min_v, max_v, med_lo, med_hi;
  sample_t pv [NUM_SLOTS];

  logic accept, full, last_j, out_take, last_res;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic cfg_wr;
  logic [SLOT_BITS-1:0] pslot;

  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_BITS'(MAX_SAMPLES));
  assign last_j   = (j == n_m1);
  assign out_take = out_valid && !out_stall;
  assign last_res = (res_idx == RES_PCT0 + slots_n - RES_BITS'(1));

  ose_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (sample),
    .head   (head)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && end_of_set) state_next = ST_PREP;
      ST_PREP:  state_next = ST_DRAIN;
      ST_DRAIN: if (last_j) state_next = ST_EMIT;
      ST_EMIT:  if (out_take && last_res) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
    ctl.ins   = accept && !full;
    ctl.drain = (state == ST_DRAIN);
    ctl.clear = (state == ST_DRAIN) && last_j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      res_idx  <= RES_MIN;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        got[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CNT_BITS'(1);
        end
      end
      if (ctl.clear) begin
        count <= '0;
      end
      if (state == ST_PREP) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          got[i] <= 1'b0;
        end
      end
      if (state == ST_DRAIN) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (acc >= tgt[i] || last_j) begin
            got[i] <= 1'b1;
          end
        end
        if (last_j) begin
          res_idx <= RES_MIN;
        end
      end
      if (out_take) begin
        res_idx <= res_idx + RES_BITS'(1);
        if (last_res) begin
          overflow <= 1'b0;
        end
      end
    end
  end

  // set size, targets and captured statistics
  always_ff @(posedge clk) begin
    if (accept && end_of_set) begin
      n <= full ? count : count + CNT_BITS'(1);
    end
    if (state == ST_PREP) begin
      n_m1    <= IDX_BITS'(n - CNT_BITS'(1));
      half    <= IDX_BITS'(n >> 1);
      odd     <= n[0];
      slots_n <= (pct_count > PCT_CNT_BITS'(NUM_SLOTS)) ? RES_BITS'(NUM_SLOTS)
                                                        : RES_BITS'(pct_count);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tgt[i] <= TGT_BITS'(pct[i]) * TGT_BITS'(n);
      end
      j   <= '0;
      acc <= TGT_BITS'(PCT_SCALE);
    end
    if (state == ST_DRAIN) begin
      j   <= j + IDX_BITS'(1);
      acc <= acc + TGT_BITS'(PCT_SCALE);
      if (j == '0) begin
        min_v <= head;
      end
      if (last_j) begin
        max_v <= head;
      end
      if (j == half) begin
        med_hi <= head;
      end
      if (half != '0 && j == half - IDX_BITS'(1)) begin
        med_lo <= head;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!got[i] && (acc >= tgt[i] || last_j)) begin
          pv[i] <= head;
        end
      end
    end
  end

  // result mux
  assign pslot = SLOT_BITS'(res_idx - RES_PCT0);

  always_comb begin
    slot = '0;
    unique case (res_idx)
      RES_MIN: begin
        kind  = KIND_MIN;
        value = sext(min_v);
      end
      RES_MAX: begin
        kind  = KIND_MAX;
        value = sext(max_v);
      end
      RES_MEDIAN: begin
        kind  = KIND_MEDIAN2;
        value = odd ? (sext(med_hi) + sext(med_hi)) : (sext(med_lo) + sext(med_hi));
      end
      default: begin
        kind  = KIND_PCT;
        slot  = pslot;
        value = sext(pv[pslot]);
      end
    endcase
  end

  assign overflowed = overflow;
  assign final_res  = last_res;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pct_count <= PCT_COUNT_RESET;
      pct[0]    <= PCT_A_RESET;
      pct[1]    <= PCT_B_RESET;
      pct[2]    <= PCT_C_RESET;
      pct[3]    <= PCT_D_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PCT_COUNT: pct_count <= pwdata[PCT_CNT_BITS-1:0];
        REG_PCT_A:     pct[0]    <= pwdata[PCT_BITS-1:0];
        REG_PCT_B:     pct[1]    <= pwdata[PCT_BITS-1:0];
        REG_PCT_C:     pct[2]    <= pwdata[PCT_BITS-1:0];
        REG_PCT_D:     pct[3]    <= pwdata[PCT_BITS-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PCT_COUNT: prdata = DATA_BITS'(pct_count);
      REG_PCT_A:     prdata = DATA_BITS'(pct[0]);
      REG_PCT_B:     prdata = DATA_BITS'(pct[1]);
      REG_PCT_C:     prdata = DATA_BITS'(pct[2]);
      REG_PCT_D:     prdata = DATA_BITS'(pct[3]);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ose_cell.sv
// one cell of the insertion-sorting chain: holds one sorted sample
// depends on ose_pkg
`default_nettype none

module ose_cell (
  input  logic               clk,
  input  logic               rst,
  input  ose_pkg::chain_ctl_t ctl,
  input  ose_pkg::sample_t   sample,
  input  logic               prev_gt,
  input  logic               prev_occ,
  input  ose_pkg::sample_t   prev_val,
  input  ose_pkg::sample_t   next_val,
  output logic               gt,
  output logic               occ,
  output ose_pkg::sample_t   val
);
  import ose_pkg::*;

  logic take_new;

  assign gt       = occ && (val > sample);
  assign take_new = gt || (!occ && prev_occ);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear) begin
      occ <= 1'b0;
    end else if (ctl.ins && (prev_gt || take_new)) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      val <= next_val;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        val <= prev_val;
      end else if (take_new) begin
        val <= sample;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ose_chain.sv
// row of sorting cells; shifts toward the head while draining
// depends on ose_pkg, ose_cell
`default_nettype none

module ose_chain (
  input  logic                clk,
  input  logic                rst,
  input  ose_pkg::chain_ctl_t ctl,
  input  ose_pkg::sample_t    sample,
  output ose_pkg::sample_t    head
);
  import ose_pkg::*;

  logic    gt_w  [MAX_SAMPLES];
  logic    occ_w [MAX_SAMPLES];
  sample_t val_w [MAX_SAMPLES];

  genvar i;
  generate
    for (i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      logic    p_gt;
      logic    p_occ;
      sample_t p_val;
      sample_t n_val;

      if (i == 0) begin : g_first
        assign p_gt  = 1'b0;
        assign p_occ = 1'b1;
        assign p_val = sample;
      end else begin : g_rest
        assign p_gt  = gt_w[i-1];
        assign p_occ = occ_w[i-1];
        assign p_val = val_w[i-1];
      end

      if (i == MAX_SAMPLES - 1) begin : g_last
        assign n_val = val_w[i];
      end else begin : g_inner
        assign n_val = val_w[i+1];
      end

      ose_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .sample   (sample),
        .prev_gt  (p_gt),
        .prev_occ (p_occ),
        .prev_val (p_val),
        .next_val (n_val),
        .gt       (gt_w[i]),
        .occ      (occ_w[i]),
        .val      (val_w[i])
      );
    end
  endgenerate

  assign head = val_w[0];

endmodule

`default_nettype wire

// File: hdl/ose_checker.sv
// port-level checks for the order statistics engine, bound to the top level
// depends on ose_pkg and order_statistics_engine_top_macros.svh
`default_nettype none
`include "order_statistics_engine_top_macros.svh"

module ose_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ose_pkg::KIND_BITS-1:0] kind,
  input  logic [ose_pkg::SLOT_BITS-1:0] slot,
  input  logic                          final_res
);
  import ose_pkg::*;

  `OSE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result item right after reset")
  `OSE_ASSERT(a_no_input_while_emit, clk, rst, out_valid |-> in_stall, "input open while emitting")
  `OSE_ASSERT(a_results_contiguous, clk, rst, out_valid && !out_stall && !final_res |=> out_valid, "gap inside a result run")
  `OSE_ASSERT(a_final_ends_run, clk, rst, out_valid && !out_stall && final_res |=> !out_valid, "result item after the final one")
  `OSE_ASSERT(a_slot_zero, clk, rst, out_valid && kind != KIND_PCT |-> slot == '0, "slot set on a non-percentile item")

endmodule

bind order_statistics_engine_top ose_checker u_ose_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .slot      (slot),
  .final_res (final_res)
);

`default_nettype wire
